[rtl/ldsc_pkg.sv]
`default_nettype none
package ldsc_pkg;

   // signed fixed point, 32 fraction bits, magnitude held within 2^62
   typedef logic signed [63:0] q_type;

   localparam q_type SAT_LIM = 64'sh4000_0000_0000_0000;
   localparam q_type Q_ONE   = 64'sh0000_0001_0000_0000;

   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int PIX_W    = 10;
   localparam int FRAC_PIX = 20;

   // register stage where each result lands, counted from the accepting edge
   localparam int MUL_LAT  = 5;
   localparam int DIV_LAT  = 66;
   localparam int PIPE_LAT = 97;

   typedef enum logic [CSR_AW-1:0] {
      CSR_K1      = 3'd0,
      CSR_K2      = 3'd1,
      CSR_P1      = 3'd2,
      CSR_P2      = 3'd3,
      CSR_FOCAL_X = 3'd4,
      CSR_FOCAL_Y = 3'd5,
      CSR_CENTRE_X = 3'd6,
      CSR_CENTRE_Y = 3'd7
   } csr_index_type;

   localparam logic [CSR_DW-1:0] RST_K1       = 32'hFB77290F;
   localparam logic [CSR_DW-1:0] RST_K2       = 32'd19853237;
   localparam logic [CSR_DW-1:0] RST_P1       = 32'd51966;
   localparam logic [CSR_DW-1:0] RST_P2       = 32'd4729;
   localparam logic [CSR_DW-1:0] RST_FOCAL_X  = 32'd480933577;
   localparam logic [CSR_DW-1:0] RST_FOCAL_Y  = 32'd479509610;
   localparam logic [CSR_DW-1:0] RST_CENTRE_X = 32'd385052836;
   localparam logic [CSR_DW-1:0] RST_CENTRE_Y = 32'd260440064;

   // saturating add, clamps to +-2^62
   function automatic q_type sat_add(input q_type a, input q_type b);
      logic signed [64:0] s;
      begin
         s = {a[63], a} + {b[63], b};
         if (s > 65'sh0_4000_0000_0000_0000) begin
            sat_add = SAT_LIM;
         end else if (s < -65'sh0_4000_0000_0000_0000) begin
            sat_add = -SAT_LIM;
         end else begin
            sat_add = s[63:0];
         end
      end
   endfunction

endpackage
`default_nettype wire

[rtl/ldsc_dly.sv]
`default_nettype none
module ldsc_dly
   #(parameter int W = 64,
     parameter int N = 4)
   (input  logic         clock,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_in;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign d_out = tap_ff[N-1];

endmodule
`default_nettype wire

[rtl/ldsc_mul.sv]
`default_nettype none
module ldsc_mul
   import ldsc_pkg::*;
   #(parameter int SHIFT = 32)
   (input  logic  clock,
    input  logic  en,
    input  q_type a_in,
    input  q_type b_in,
    output q_type p_out);

   localparam logic [125:0] LIM_W = 126'h4000_0000_0000_0000;

   logic [62:0]  ua_ff, ub_ff, ua_in, ub_in;
   logic [63:0]  p00_ff, p00_in;
   logic [62:0]  p01_ff, p01_in, p10_ff, p10_in;
   logic [61:0]  p11_ff, p11_in;
   logic [63:0]  mid_ff, mid_in;
   logic [125:0] lohi_ff, lohi_in;
   logic [125:0] prod_ff, prod_in;
   logic [3:0]   neg_ff, neg_in;
   q_type        res_ff, res_in;
   logic [125:0] shifted;
   logic [63:0]  mag;

   always_comb begin
      ua_in = a_in[63] ? 63'(-a_in) : a_in[62:0];
      ub_in = b_in[63] ? 63'(-b_in) : b_in[62:0];
      // four partial products of the 32-bit low and 31-bit high halves
      p00_in = 64'(ua_ff[31:0]) * 64'(ub_ff[31:0]);
      p01_in = 63'(63'(ua_ff[31:0]) * 63'(ub_ff[62:32]));
      p10_in = 63'(63'(ua_ff[62:32]) * 63'(ub_ff[31:0]));
      p11_in = 62'(62'(ua_ff[62:32]) * 62'(ub_ff[62:32]));
      mid_in = 64'(p01_ff) + 64'(p10_ff);
      lohi_in = {p11_ff, p00_ff};
      prod_in = lohi_ff + {30'b0, mid_ff, 32'b0};
      shifted = prod_ff >> SHIFT;
      mag = (shifted > LIM_W) ? SAT_LIM : shifted[63:0];
      res_in = neg_ff[3] ? -q_type'(mag) : q_type'(mag);
      neg_in = {neg_ff[2:0], a_in[63] ^ b_in[63]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         mid_ff  <= mid_in;
         lohi_ff <= lohi_in;
         prod_ff <= prod_in;
         res_ff  <= res_in;
         neg_ff  <= neg_in;
      end
   end

   assign p_out = res_ff;

endmodule
`default_nettype wire

[rtl/ldsc_div.sv]
`default_nettype none
module ldsc_div
   import ldsc_pkg::*;
   (input  logic              clock,
    input  logic              en,
    input  logic [PIX_W-1:0]  pix_in,
    input  logic [31:0]       centre_in,
    input  logic [31:0]       focal_in,
    output q_type             q_out);

   localparam int STEPS = 64;

   logic [31:0] rem_ff [STEPS+1];
   logic [63:0] quo_ff [STEPS+1];
   logic [31:0] num_ff [STEPS+1];
   logic        neg_ff [STEPS+1];
   logic [31:0] fdiv;
   logic [32:0] dif_a, dif_b;
   q_type       res_ff, res_in;
   logic [63:0] mag;

   assign fdiv  = (focal_in == 32'd0) ? 32'd1 : focal_in;
   assign dif_a = {3'b0, pix_in, 20'b0} - {1'b0, centre_in};
   assign dif_b = {1'b0, centre_in} - {3'b0, pix_in, 20'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         num_ff[0] <= dif_a[32] ? dif_b[31:0] : dif_a[31:0];
         neg_ff[0] <= dif_a[32];
      end
   end

   // restoring division of |d| * 2^32 by the focal length, one quotient bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = STEPS - 1 - k;
      logic        nb;
      logic [32:0] trial;
      logic        ge;
      logic [31:0] rem_in;

      if (BIT >= 32) begin : g_num
         assign nb = num_ff[k][BIT-32];
      end else begin : g_zero
         assign nb = 1'b0;
      end

      always_comb begin
         trial  = {rem_ff[k], nb};
         ge     = trial >= {1'b0, fdiv};
         rem_in = ge ? 32'(trial - {1'b0, fdiv}) : trial[31:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= {quo_ff[k][62:0], ge};
            num_ff[k+1] <= num_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_comb begin
      mag    = (|quo_ff[STEPS][63:62]) ? SAT_LIM : {2'b0, quo_ff[STEPS][61:0]};
      res_in = neg_ff[STEPS] ? -q_type'(mag) : q_type'(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign q_out = res_ff;

endmodule
`default_nettype wire

[rtl/lens_distortion_source_coordinate.sv]
// Brown-Conrady lens correction address generator. Each word on req carries one pixel
// (column, row) of the undistorted image; the matching word on rsp gives the source pixel
// in the camera image and a flag that is 0 when the source falls outside the image, in
// which case both coordinates read 0 and the caller writes black. One word is taken per
// clock unless rsp stalls, and results leave in order; the depth is set by the 64-stage
// bit-per-stage divider that normalizes by the focal length, followed by five chained
// 5-stage multipliers. A stall on rsp holds the whole pipeline. Coefficients are signed
// Q4.28, focal lengths and principal point unsigned Q12.20; the user must write them
// through csr only while no pixel is in flight, which the block itself does not enforce.
`default_nettype none
module lens_distortion_source_coordinate
   import ldsc_pkg::*;
   #(parameter int IMG_COLS = 1024,
     parameter int IMG_ROWS = 1024)
   (input  logic              clock,
    input  logic              reset,
    input  logic              req_tvalid,
    output logic              req_tready,
    input  logic [23:0]       req_tdata,   // out_col[9:0], out_row[19:10], zero pad
    output logic              rsp_tvalid,
    input  logic              rsp_tready,
    output logic [23:0]       rsp_tdata,   // src_col[9:0], src_row[19:10], zero pad
    output logic              rsp_tuser,   // inside_res
    input  logic              csr_we,
    input  logic [CSR_AW-1:0] csr_addr,
    input  logic [CSR_DW-1:0] csr_wdata);

   localparam logic [63:0] COL_LIM = 64'(IMG_COLS) << FRAC_PIX;
   localparam logic [63:0] ROW_LIM = 64'(IMG_ROWS) << FRAC_PIX;

   logic [CSR_DW-1:0] k1_ff, k2_ff, p1_ff, p2_ff;
   logic [CSR_DW-1:0] fx_ff, fy_ff, cx_ff, cy_ff;
   logic              en;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;

   q_type k1, k2, p1, p2, fx, fy, cx, cy;
   q_type x, y, xx, yy, xy;
   q_type r2_ff, s2x_ff, s2y_ff, tx_ff, ty_ff;
   q_type r4, kr2, a1_ff, a1_d, k2r4, radial_ff;
   q_type x_d, y_d, xr, yr;
   q_type p1xy, p2xy, p2tx, p1ty, p1xy_d, p2xy_d, p2tx_d, p1ty_d;
   q_type sx1_ff, sy1_ff, xd_ff, yd_ff, um, vm, ud_ff, vd_ff;
   logic [PIX_W-1:0] col_ff, row_ff, col_in, row_in;
   logic             inside_ff, inside_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= RST_K1;
         k2_ff <= RST_K2;
         p1_ff <= RST_P1;
         p2_ff <= RST_P2;
         fx_ff <= RST_FOCAL_X;
         fy_ff <= RST_FOCAL_Y;
         cx_ff <= RST_CENTRE_X;
         cy_ff <= RST_CENTRE_Y;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_K1:       k1_ff <= csr_wdata;
            CSR_K2:       k2_ff <= csr_wdata;
            CSR_P1:       p1_ff <= csr_wdata;
            CSR_P2:       p2_ff <= csr_wdata;
            CSR_FOCAL_X:  fx_ff <= csr_wdata;
            CSR_FOCAL_Y:  fy_ff <= csr_wdata;
            CSR_CENTRE_X: cx_ff <= csr_wdata;
            CSR_CENTRE_Y: cy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign k1 = {{32{k1_ff[31]}}, k1_ff};
   assign k2 = {{32{k2_ff[31]}}, k2_ff};
   assign p1 = {{32{p1_ff[31]}}, p1_ff};
   assign p2 = {{32{p2_ff[31]}}, p2_ff};
   assign fx = {32'b0, fx_ff};
   assign fy = {32'b0, fy_ff};
   assign cx = {32'b0, cx_ff};
   assign cy = {32'b0, cy_ff};

   // whole pipeline advances together unless the output word is stalled
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[PIPE_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // normalized coordinates
   ldsc_div u_div_x (.clock, .en, .pix_in(req_tdata[9:0]), .centre_in(cx_ff),
                     .focal_in(fx_ff), .q_out(x));
   ldsc_div u_div_y (.clock, .en, .pix_in(req_tdata[19:10]), .centre_in(cy_ff),
                     .focal_in(fy_ff), .q_out(y));

   // squares and cross term
   ldsc_mul #(.SHIFT(32)) u_xx (.clock, .en, .a_in(x), .b_in(x), .p_out(xx));
   ldsc_mul #(.SHIFT(32)) u_yy (.clock, .en, .a_in(y), .b_in(y), .p_out(yy));
   ldsc_mul #(.SHIFT(32)) u_xy (.clock, .en, .a_in(x), .b_in(y), .p_out(xy));

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff  <= sat_add(xx, yy);
         s2x_ff <= sat_add(xx, xx);
         s2y_ff <= sat_add(yy, yy);
         tx_ff  <= sat_add(r2_ff, s2x_ff);
         ty_ff  <= sat_add(r2_ff, s2y_ff);
      end
   end

   // radial factor: 1 + k1 r^2 + k2 r^4
   ldsc_mul #(.SHIFT(32)) u_r4  (.clock, .en, .a_in(r2_ff), .b_in(r2_ff), .p_out(r4));
   ldsc_mul #(.SHIFT(28)) u_kr2 (.clock, .en, .a_in(k1), .b_in(r2_ff), .p_out(kr2));
   ldsc_mul #(.SHIFT(28)) u_kr4 (.clock, .en, .a_in(k2), .b_in(r4), .p_out(k2r4));
   ldsc_dly #(.W(64), .N(4)) u_dly_a1 (.clock, .en, .d_in(a1_ff), .d_out(a1_d));

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= sat_add(Q_ONE, kr2);
         radial_ff <= sat_add(a1_d, k2r4);
      end
   end

   // tangential terms
   ldsc_mul #(.SHIFT(27)) u_p1xy (.clock, .en, .a_in(p1), .b_in(xy), .p_out(p1xy));
   ldsc_mul #(.SHIFT(27)) u_p2xy (.clock, .en, .a_in(p2), .b_in(xy), .p_out(p2xy));
   ldsc_mul #(.SHIFT(28)) u_p2tx (.clock, .en, .a_in(p2), .b_in(tx_ff), .p_out(p2tx));
   ldsc_mul #(.SHIFT(28)) u_p1ty (.clock, .en, .a_in(p1), .b_in(ty_ff), .p_out(p1ty));
   ldsc_dly #(.W(64), .N(12)) u_dly_p1xy (.clock, .en, .d_in(p1xy), .d_out(p1xy_d));
   ldsc_dly #(.W(64), .N(13)) u_dly_p2xy (.clock, .en, .d_in(p2xy), .d_out(p2xy_d));
   ldsc_dly #(.W(64), .N(11)) u_dly_p2tx (.clock, .en, .d_in(p2tx), .d_out(p2tx_d));
   ldsc_dly #(.W(64), .N(10)) u_dly_p1ty (.clock, .en, .d_in(p1ty), .d_out(p1ty_d));

   // distorted normalized coordinates
   ldsc_dly #(.W(64), .N(17)) u_dly_x (.clock, .en, .d_in(x), .d_out(x_d));
   ldsc_dly #(.W(64), .N(17)) u_dly_y (.clock, .en, .d_in(y), .d_out(y_d));
   ldsc_mul #(.SHIFT(32)) u_xr (.clock, .en, .a_in(x_d), .b_in(radial_ff), .p_out(xr));
   ldsc_mul #(.SHIFT(32)) u_yr (.clock, .en, .a_in(y_d), .b_in(radial_ff), .p_out(yr));

   always_ff @(posedge clock) begin
      if (en) begin
         sx1_ff <= sat_add(xr, p1xy_d);
         sy1_ff <= sat_add(yr, p1ty_d);
         xd_ff  <= sat_add(sx1_ff, p2tx_d);
         yd_ff  <= sat_add(sy1_ff, p2xy_d);
      end
   end

   // back to pixels
   ldsc_mul #(.SHIFT(32)) u_um (.clock, .en, .a_in(fx), .b_in(xd_ff), .p_out(um));
   ldsc_mul #(.SHIFT(32)) u_vm (.clock, .en, .a_in(fy), .b_in(yd_ff), .p_out(vm));

   always_comb begin
      inside_in = !ud_ff[63] && !vd_ff[63] && (ud_ff < COL_LIM) && (vd_ff < ROW_LIM);
      col_in    = inside_in ? ud_ff[FRAC_PIX +: PIX_W] : '0;
      row_in    = inside_in ? vd_ff[FRAC_PIX +: PIX_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ud_ff     <= sat_add(um, cx);
         vd_ff     <= sat_add(vm, cy);
         col_ff    <= col_in;
         row_ff    <= row_in;
         inside_ff <= inside_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = {4'b0, row_ff, col_ff};
   assign rsp_tuser  = inside_ff;

endmodule
`default_nettype wire
